// ===== sv/ffa_pkg.sv =====
// shared types, constants and sequencer codes for the first-fit allocator
package ffa_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int CFG_IDX_W        = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 8'd1;

  // operation and status codes
  localparam logic       FUNC_ALLOC = 1'b0;
  localparam logic       FUNC_FREE  = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_NOTFND  = 2'd2;

  // sequencer states
  localparam int SW = 4;
  localparam logic [SW-1:0] S_IDLE  = 4'd0;
  localparam logic [SW-1:0] S_A_RD  = 4'd1;
  localparam logic [SW-1:0] S_A_CK  = 4'd2;
  localparam logic [SW-1:0] S_SH_RD = 4'd3;
  localparam logic [SW-1:0] S_SH_WR = 4'd4;
  localparam logic [SW-1:0] S_F_RD  = 4'd5;
  localparam logic [SW-1:0] S_F_CK  = 4'd6;
  localparam logic [SW-1:0] S_P_RD  = 4'd7;
  localparam logic [SW-1:0] S_P_CK  = 4'd8;
  localparam logic [SW-1:0] S_EVAL  = 4'd9;
  localparam logic [SW-1:0] S_U_RD  = 4'd10;
  localparam logic [SW-1:0] S_U_CK  = 4'd11;
  localparam logic [SW-1:0] S_MERGE = 4'd12;
  localparam logic [SW-1:0] S_I_RD  = 4'd13;
  localparam logic [SW-1:0] S_I_WR  = 4'd14;
  localparam logic [SW-1:0] S_FIN   = 4'd15;

  typedef struct packed {
    logic        func;
    logic [27:0] req_bytes;
    logic [31:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_addr;
    logic [31:0] block_bytes;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } cfg_item_t;

  // one table entry: block start and length
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } blk_t;

endpackage

// ===== sv/ffa_if.sv =====
// valid/ready channel interfaces for request, result and configuration items
interface ffa_in_if import ffa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffa_out_if import ffa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffa_cfg_if import ffa_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ffa_ram.sv =====
// generic single-write, single-read ram with registered read data
module ffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/ffa_seq.sv =====
// sequencer and shared compare/add datapath that walks the block tables
module ffa_seq import ffa_pkg::*; #(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int FAW = $clog2(MAX_BLOCKS + 1),
  parameter int UAW = $clog2(MAX_BLOCKS)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  in_item_t       in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output out_item_t      out_data,
  input  logic           cfg_valid,
  input  cfg_item_t      cfg_data,
  output logic           f_we,
  output logic [FAW-1:0] f_waddr,
  output blk_t           f_wdata,
  output logic [FAW-1:0] f_raddr,
  input  blk_t           f_rdata,
  output logic           u_we,
  output logic [UAW-1:0] u_waddr,
  output blk_t           u_wdata,
  output logic [UAW-1:0] u_raddr,
  input  blk_t           u_rdata
);
  localparam int FCW = $clog2(MAX_BLOCKS + 2);
  localparam int UCW = $clog2(MAX_BLOCKS + 1);
  localparam logic [FCW-1:0] FREE_DEPTH = FCW'(MAX_BLOCKS + 1);
  localparam logic [UCW-1:0] USED_DEPTH = UCW'(MAX_BLOCKS);
  localparam logic [FCW-1:0] F1 = FCW'(1);
  localparam logic [UCW-1:0] U1 = UCW'(1);
  localparam logic [31:0]    HDR = 32'(HEADER_BYTES);

  logic [SW-1:0]  state_r, state_nxt;
  logic [31:0]    base_r, bytes_r;
  logic           init_r, init_nxt;
  logic [FCW-1:0] fc_r, fc_nxt, idx_r, idx_nxt, pos_r, pos_nxt;
  logic [UCW-1:0] uc_r, uc_nxt, u_r, u_nxt;
  logic [31:0]    cur_r, cur_nxt, len_r, len_nxt;
  blk_t           prev_r, prev_nxt, next_r, next_nxt;
  logic           nvld_r, nvld_nxt, nm_r, nm_nxt, bm_r, bm_nxt;
  logic           ov_r, ov_nxt;
  out_item_t      res_r, res_nxt;
  out_item_t      out_r, out_nxt;
  logic [31:0]    size;
  logic [31:0]    remain;
  logic           nm, bm;

  assign in_ready  = (state_r == S_IDLE) && !init_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // shared arithmetic
  assign size   = HDR + ((32'(in_data.req_bytes) + 32'd15) & ~32'd15);
  assign remain = f_rdata.len - len_r;
  assign nm     = nvld_r && ((next_r.start - cur_r) == len_r);
  assign bm     = (pos_r != '0) && ((cur_r - prev_r.start) == prev_r.len);

  // region registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      bytes_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_data.idx == CFG_REGION_BASE) begin
        base_r <= cfg_data.data;
      end else if (cfg_data.idx == CFG_REGION_BYTES) begin
        bytes_r <= cfg_data.data;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    fc_nxt    = fc_r;
    uc_nxt    = uc_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    u_nxt     = u_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    prev_nxt  = prev_r;
    next_nxt  = next_r;
    nvld_nxt  = nvld_r;
    nm_nxt    = nm_r;
    bm_nxt    = bm_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r && !out_ready;
    f_we      = 1'b0;
    f_waddr   = idx_r[FAW-1:0];
    f_wdata   = next_r;
    f_raddr   = idx_r[FAW-1:0];
    u_we      = 1'b0;
    u_waddr   = uc_r[UAW-1:0];
    u_wdata   = u_rdata;
    u_raddr   = u_r[UAW-1:0];
    if (cfg_valid && (cfg_data.idx == CFG_REGION_BASE || cfg_data.idx == CFG_REGION_BYTES)) begin
      init_nxt = 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (init_r) begin
          // reinitialise: one free block covering the region
          f_we    = 1'b1;
          f_waddr = '0;
          f_wdata = '{start: base_r, len: bytes_r};
          fc_nxt  = F1;
          uc_nxt  = '0;
          if (!cfg_valid) begin
            init_nxt = 1'b0;
          end
        end else if (in_valid) begin
          res_nxt = '{status: ST_NOMEM, payload_addr: '0, block_bytes: '0};
          idx_nxt = '0;
          u_nxt   = '0;
          pos_nxt = '0;
          cur_nxt = in_data.free_addr - HDR;
          len_nxt = size;
          if (in_data.func == FUNC_ALLOC) begin
            state_nxt = (uc_r >= USED_DEPTH) ? S_FIN : S_A_RD;
          end else begin
            state_nxt = S_F_RD;
          end
        end
      end
      // first-fit scan
      S_A_RD: begin
        state_nxt = (idx_r < fc_r) ? S_A_CK : S_FIN;
      end
      S_A_CK: begin
        if (f_rdata.len >= len_r) begin
          u_we    = 1'b1;
          u_wdata = '{start: f_rdata.start, len: len_r};
          uc_nxt  = uc_r + U1;
          res_nxt = '{status: ST_OK, payload_addr: f_rdata.start + HDR, block_bytes: len_r};
          if (remain > HDR) begin
            f_we      = 1'b1;
            f_wdata   = '{start: f_rdata.start + len_r, len: remain};
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else begin
          idx_nxt   = idx_r + F1;
          state_nxt = S_A_RD;
        end
      end
      // close the gap at idx: entry idx+1 moves down
      S_SH_RD: begin
        f_raddr = FAW'(idx_r + F1);
        if (idx_r + F1 < fc_r) begin
          state_nxt = S_SH_WR;
        end else begin
          fc_nxt    = fc_r - F1;
          state_nxt = S_FIN;
        end
      end
      S_SH_WR: begin
        f_we      = 1'b1;
        f_wdata   = f_rdata;
        idx_nxt   = idx_r + F1;
        state_nxt = S_SH_RD;
      end
      // used table lookup
      S_F_RD: begin
        if (u_r < uc_r) begin
          state_nxt = S_F_CK;
        end else begin
          res_nxt.status = ST_NOTFND;
          state_nxt      = S_FIN;
        end
      end
      S_F_CK: begin
        if (u_rdata.start == cur_r) begin
          len_nxt   = u_rdata.len;
          state_nxt = S_P_RD;
        end else begin
          u_nxt     = u_r + U1;
          state_nxt = S_F_RD;
        end
      end
      // find insertion point in the free table
      S_P_RD: begin
        f_raddr = pos_r[FAW-1:0];
        if (pos_r < fc_r) begin
          state_nxt = S_P_CK;
        end else begin
          nvld_nxt  = 1'b0;
          state_nxt = S_EVAL;
        end
      end
      S_P_CK: begin
        if (f_rdata.start < cur_r) begin
          prev_nxt  = f_rdata;
          pos_nxt   = pos_r + F1;
          state_nxt = S_P_RD;
        end else begin
          next_nxt  = f_rdata;
          nvld_nxt  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        nm_nxt = nm;
        bm_nxt = bm;
        if (!nm && !bm && fc_r >= FREE_DEPTH) begin
          state_nxt = S_FIN;
        end else begin
          uc_nxt    = uc_r - U1;
          state_nxt = S_U_RD;
        end
      end
      // last used entry fills the freed slot
      S_U_RD: begin
        u_raddr   = uc_r[UAW-1:0];
        state_nxt = S_U_CK;
      end
      S_U_CK: begin
        u_we      = 1'b1;
        u_waddr   = u_r[UAW-1:0];
        u_wdata   = u_rdata;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        res_nxt = '{status: ST_OK, payload_addr: '0, block_bytes: len_r};
        if (nm_r && bm_r) begin
          f_we      = 1'b1;
          f_waddr   = FAW'(pos_r - F1);
          f_wdata   = '{start: prev_r.start, len: prev_r.len + len_r + next_r.len};
          idx_nxt   = pos_r;
          state_nxt = S_SH_RD;
        end else if (nm_r) begin
          f_we      = 1'b1;
          f_waddr   = pos_r[FAW-1:0];
          f_wdata   = '{start: cur_r, len: next_r.len + len_r};
          state_nxt = S_FIN;
        end else if (bm_r) begin
          f_we      = 1'b1;
          f_waddr   = FAW'(pos_r - F1);
          f_wdata   = '{start: prev_r.start, len: prev_r.len + len_r};
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = fc_r;
          state_nxt = S_I_RD;
        end
      end
      // open a slot at pos: entry idx-1 moves up
      S_I_RD: begin
        f_raddr = FAW'(idx_r - F1);
        if (idx_r > pos_r) begin
          state_nxt = S_I_WR;
        end else begin
          f_we      = 1'b1;
          f_waddr   = pos_r[FAW-1:0];
          f_wdata   = '{start: cur_r, len: len_r};
          fc_nxt    = fc_r + F1;
          state_nxt = S_FIN;
        end
      end
      S_I_WR: begin
        f_we      = 1'b1;
        f_wdata   = f_rdata;
        idx_nxt   = idx_r - F1;
        state_nxt = S_I_RD;
      end
      // hand the result to the output register once it is free
      S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          out_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_r  <= 1'b1;
      fc_r    <= F1;
      uc_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      fc_r    <= fc_nxt;
      uc_r    <= uc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    u_r    <= u_nxt;
    cur_r  <= cur_nxt;
    len_r  <= len_nxt;
    prev_r <= prev_nxt;
    next_r <= next_nxt;
    nvld_r <= nvld_nxt;
    nm_r   <= nm_nxt;
    bm_r   <= bm_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end
endmodule

// ===== sv/first_fit_block_allocator.sv =====
// top level of the first-fit block allocator with free-block coalescing
//
//   channel  | dir | payload
//   in_ch    | in  | func, req_bytes, free_addr
//   out_ch   | out | status, payload_addr, block_bytes
//   cfg_ch   | in  | idx (0 region_base, 1 region_bytes), data
//
// one item at a time; each table step is a read then a compare or write on
// one ram port. reset and each region write rewrite the first free entry
// before the next item is taken. a waiting result holds out_ch; the next
// item is taken meanwhile and its result waits in the final step until the
// output register frees.
module first_fit_block_allocator import ffa_pkg::*; #(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ffa_in_if.sink    in_ch,
  ffa_out_if.source out_ch,
  ffa_cfg_if.sink   cfg_ch
);
  localparam int FAW = $clog2(MAX_BLOCKS + 1);
  localparam int UAW = $clog2(MAX_BLOCKS);

  logic           f_we, u_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [UAW-1:0] u_waddr, u_raddr;
  blk_t           f_wdata, f_rdata, u_wdata, u_rdata;

  assign cfg_ch.ready = 1'b1;

  // free table, address ordered
  ffa_ram #(.WIDTH($bits(blk_t)), .DEPTH(MAX_BLOCKS + 1), .AW(FAW)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  // used table, unordered
  ffa_ram #(.WIDTH($bits(blk_t)), .DEPTH(MAX_BLOCKS), .AW(UAW)) u_used_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  ffa_seq #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES),
            .FAW(FAW), .UAW(UAW)) u_seq (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_valid(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .f_we(f_we), .f_waddr(f_waddr), .f_wdata(f_wdata),
    .f_raddr(f_raddr), .f_rdata(f_rdata),
    .u_we(u_we), .u_waddr(u_waddr), .u_wdata(u_wdata),
    .u_raddr(u_raddr), .u_rdata(u_rdata)
  );
endmodule

// ===== sv/ffa_checker.sv =====
// port-level checks for the allocator, bound to the top level
module ffa_checker import ffa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  // a pending result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // an accepted item leaves the block busy in the following cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("took a second item while busy");

  // only a granted allocate reports an address
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.payload_addr == '0
      && out_data.block_bytes == '0)
    else $error("failed request carries an address or size");
endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
